@@ src/btmx_pkg.sv @@
// Shared constants and types for the binary trie maximum-xor core.
`default_nettype none
package btmx_pkg;

  localparam int KeyBits   = 49;
  localparam int NodeCount = 65536;
  localparam int NodeBits  = $clog2(NodeCount);
  localparam int CntBits   = NodeBits + 1;
  localparam int LvlBits   = $clog2(KeyBits);

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  typedef logic [KeyBits-1:0]       key_t;
  typedef logic [NodeBits-1:0]      node_t;
  typedef logic [1:0][NodeBits-1:0] row_t;
  typedef logic [CntBits-1:0]       cnt_t;
  typedef logic [LvlBits-1:0]       lvl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

endpackage
`default_nettype wire

@@ src/binary_trie_max_xor_core.sv @@
// Binary trie over 49-bit keys: insert and maximum-xor query, one trie level per cycle.
// A walking insert or query steps through the 49 levels, one row of the link memory read per
// cycle, and strobes its result from the result register once the last level is done.
// A refused insert or a query of an empty trie strobes its result in the next cycle.
// A new request is taken only once the previous walk is done; busy is high while a walk runs.
// Reset clears the root links and sets the free pointer to node 1; no clearing pass.
`default_nettype none
module binary_trie_max_xor_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    req_type_i,
  input  wire btmx_pkg::key_t          key_i,
  output logic                         result_valid_o,
  output btmx_pkg::key_t               best_xor_o,
  output logic                         set_empty_o,
  output logic                         pool_full_o
);

  btmx_pkg::state_e state_q, state_d;
  logic             req_q;
  btmx_pkg::key_t   key_q;
  btmx_pkg::key_t   acc_q, acc_d;
  btmx_pkg::lvl_t   lvl_q, lvl_d;
  btmx_pkg::node_t  cur_q, cur_d;
  logic             cur_root_q, cur_root_d;
  logic             fresh_q, fresh_d;
  btmx_pkg::cnt_t   nf_q, nf_d;
  btmx_pkg::row_t   root_q, root_d;

  logic             valid_q, valid_d;
  btmx_pkg::key_t   best_q, best_d;
  logic             empty_q, empty_d;
  logic             full_q, full_d;

  btmx_pkg::row_t   mem [btmx_pkg::NodeCount];
  btmx_pkg::row_t   rdata_q;
  btmx_pkg::node_t  raddr;
  logic             re;
  logic             we;
  btmx_pkg::node_t  waddr;
  btmx_pkg::row_t   wdata;

  logic             accept;
  btmx_pkg::row_t   row;
  btmx_pkg::row_t   new_row;
  logic             kbit;
  logic             last;
  logic             stop;
  btmx_pkg::node_t  nxt;
  btmx_pkg::node_t  nf_node;
  logic             refuse;

  assign accept  = start && !busy;
  assign busy    = (state_q == btmx_pkg::ST_WALK);
  assign nf_node = nf_q[btmx_pkg::NodeBits-1:0];
  assign refuse  = (btmx_pkg::cnt_t'(btmx_pkg::NodeCount) - nf_q)
                   < btmx_pkg::cnt_t'(btmx_pkg::KeyBits);

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    lvl_d      = lvl_q;
    cur_d      = cur_q;
    cur_root_d = cur_root_q;
    fresh_d    = fresh_q;
    nf_d       = nf_q;
    root_d     = root_q;
    valid_d    = 1'b0;
    best_d     = best_q;
    empty_d    = empty_q;
    full_d     = full_q;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = cur_q;
    wdata      = '0;
    stop       = 1'b0;
    nxt        = '0;
    new_row    = '0;
    row        = fresh_q ? '0 : (cur_root_q ? root_q : rdata_q);
    kbit       = key_q[lvl_q];
    last       = (lvl_q == '0);

    unique case (state_q)
      btmx_pkg::ST_IDLE: begin
        if (accept) begin
          acc_d      = '0;
          lvl_d      = btmx_pkg::lvl_t'(btmx_pkg::KeyBits - 1);
          cur_d      = '0;
          cur_root_d = 1'b1;
          fresh_d    = 1'b0;
          if (req_type_i == btmx_pkg::ReqInsert && refuse) begin
            valid_d = 1'b1;
            best_d  = '0;
            empty_d = 1'b0;
            full_d  = 1'b1;
          end else if (req_type_i == btmx_pkg::ReqQuery && root_q == '0) begin
            valid_d = 1'b1;
            best_d  = '0;
            empty_d = 1'b1;
            full_d  = 1'b0;
          end else begin
            state_d = btmx_pkg::ST_WALK;
          end
        end
      end
      btmx_pkg::ST_WALK: begin
        if (req_q == btmx_pkg::ReqInsert) begin
          if (!fresh_q && row[kbit] != '0) begin
            nxt = row[kbit];
          end else begin
            nxt           = nf_node;
            new_row       = row;
            new_row[kbit] = nf_node;
            nf_d          = nf_q + btmx_pkg::cnt_t'(1);
            fresh_d       = 1'b1;
            if (cur_root_q) begin
              root_d = new_row;
            end else begin
              we    = 1'b1;
              wdata = new_row;
            end
          end
        end else begin
          if (row[~kbit] != '0) begin
            nxt          = row[~kbit];
            acc_d[lvl_q] = 1'b1;
          end else if (row[kbit] != '0) begin
            nxt = row[kbit];
          end else begin
            stop = 1'b1;
          end
        end
        re         = !last && !stop;
        raddr      = nxt;
        cur_d      = nxt;
        cur_root_d = 1'b0;
        lvl_d      = lvl_q - btmx_pkg::lvl_t'(1);
        if (last || stop) begin
          state_d = btmx_pkg::ST_IDLE;
          valid_d = 1'b1;
          best_d  = (req_q == btmx_pkg::ReqQuery) ? acc_d : '0;
          empty_d = 1'b0;
          full_d  = 1'b0;
        end
      end
      default: begin
        state_d = btmx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= btmx_pkg::ST_IDLE;
      nf_q       <= btmx_pkg::cnt_t'(1);
      root_q     <= '0;
      valid_q    <= 1'b0;
      fresh_q    <= 1'b0;
      cur_root_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      nf_q       <= nf_d;
      root_q     <= root_d;
      valid_q    <= valid_d;
      fresh_q    <= fresh_d;
      cur_root_q <= cur_root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      key_q <= key_i;
    end
    acc_q   <= acc_d;
    lvl_q   <= lvl_d;
    cur_q   <= cur_d;
    best_q  <= best_d;
    empty_q <= empty_d;
    full_q  <= full_d;
  end

  // link memory, one row of two child links per node
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign result_valid_o = valid_q;
  assign best_xor_o     = best_q;
  assign set_empty_o    = empty_q;
  assign pool_full_o    = full_q;

`ifndef NO_ASSERTIONS
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || result_valid_o))
    else $error("accepted request neither walked nor reported");

  a_write_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (busy && req_q == btmx_pkg::ReqInsert && !cur_root_q))
    else $error("link memory written outside an insert walk");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q != '0) && (nf_q <= btmx_pkg::cnt_t'(btmx_pkg::NodeCount)))
    else $error("free pointer out of range");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pool_full_o) |-> (best_xor_o == '0 && !set_empty_o))
    else $error("refused insert with stray result fields");

  a_no_strobe_mid_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !result_valid_o)
    else $error("result strobe during a walk");
`endif

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for binary_trie_max_xor_core: directed, random and pool exhaustion requests.
module testbench;

  typedef struct packed {
    btmx_pkg::key_t best_xor;
    logic           set_empty;
    logic           pool_full;
  } xor_result_t;

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           start      = 1'b0;
  logic           req_type_i = btmx_pkg::ReqInsert;
  btmx_pkg::key_t key_i      = '0;
  logic           busy;
  logic           result_valid_o;
  btmx_pkg::key_t best_xor_o;
  logic           set_empty_o;
  logic           pool_full_o;

  binary_trie_max_xor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .key_i          (key_i),
    .result_valid_o (result_valid_o),
    .best_xor_o     (best_xor_o),
    .set_empty_o    (set_empty_o),
    .pool_full_o    (pool_full_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // trie model: link value 0 means no child, node 0 is the root
  btmx_pkg::node_t trie_link [0:btmx_pkg::NodeCount-1][0:1];
  int              next_node = 1;
  btmx_pkg::key_t  trie_keys [$];
  xor_result_t     pending_results [$];
  int              mismatch_count = 0;
  int              sender_idle_pct = 0;

  function automatic xor_result_t predict_trie_result(input logic req,
                                                      input btmx_pkg::key_t k);
    xor_result_t     res;
    btmx_pkg::node_t cur;
    btmx_pkg::node_t nxt;
    logic            want;
    res = '0;
    cur = '0;
    if (req == btmx_pkg::ReqInsert) begin
      if (btmx_pkg::NodeCount - next_node < btmx_pkg::KeyBits) begin
        res.pool_full = 1'b1;
      end else begin
        for (int lvl = btmx_pkg::KeyBits - 1; lvl >= 0; lvl--) begin
          nxt = trie_link[cur][k[lvl]];
          if (nxt == '0) begin
            nxt = btmx_pkg::node_t'(next_node);
            next_node++;
            trie_link[nxt][0] = '0;
            trie_link[nxt][1] = '0;
            trie_link[cur][k[lvl]] = nxt;
          end
          cur = nxt;
        end
      end
    end else if (trie_link[0][0] == '0 && trie_link[0][1] == '0) begin
      res.set_empty = 1'b1;
    end else begin
      for (int lvl = btmx_pkg::KeyBits - 1; lvl >= 0; lvl--) begin
        want = ~k[lvl];
        if (trie_link[cur][want] != '0) begin
          res.best_xor[lvl] = 1'b1;
          cur = trie_link[cur][want];
        end else if (trie_link[cur][~want] != '0) begin
          cur = trie_link[cur][~want];
        end else begin
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    xor_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (best_xor_o !== want.best_xor)
          report_mismatch($sformatf("best_xor %h, want %h", best_xor_o, want.best_xor));
        if (set_empty_o !== want.set_empty)
          report_mismatch($sformatf("set_empty %b, want %b", set_empty_o, want.set_empty));
        if (pool_full_o !== want.pool_full)
          report_mismatch($sformatf("pool_full %b, want %b", pool_full_o, want.pool_full));
      end
    end
  end

  // drive one request, hold it until taken, then maybe leave a gap
  task automatic issue_request(input logic req, input btmx_pkg::key_t k);
    xor_result_t res;
    start      <= 1'b1;
    req_type_i <= req;
    key_i      <= k;
    do @(posedge clk_i); while (busy !== 1'b0);
    res = predict_trie_result(req, k);
    pending_results.push_back(res);
    if (req == btmx_pkg::ReqInsert && !res.pool_full)
      trie_keys.push_back(k);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
  endtask

  function automatic btmx_pkg::key_t rand_key();
    return btmx_pkg::key_t'({$urandom(), $urandom()});
  endfunction

  function automatic btmx_pkg::key_t near_stored_key();
    if (trie_keys.size() == 0)
      return rand_key();
    return trie_keys[$urandom_range(trie_keys.size() - 1)] ^
           (rand_key() >> $urandom_range(btmx_pkg::KeyBits - 1));
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      issue_request(btmx_pkg::ReqInsert, rand_key());
    else if (r < 50)
      issue_request(btmx_pkg::ReqInsert, near_stored_key());
    else if (r < 75)
      issue_request(btmx_pkg::ReqQuery, rand_key());
    else
      issue_request(btmx_pkg::ReqQuery, near_stored_key());
  endtask

  task automatic test_empty_query();
    issue_request(btmx_pkg::ReqQuery, '0);
    issue_request(btmx_pkg::ReqQuery, '1);
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(49'h1_5555_5555_5555));
  endtask

  task automatic test_extreme_keys();
    issue_request(btmx_pkg::ReqInsert, '0);
    issue_request(btmx_pkg::ReqQuery, '0);
    issue_request(btmx_pkg::ReqQuery, '1);
    issue_request(btmx_pkg::ReqInsert, '0);
    issue_request(btmx_pkg::ReqInsert, '1);
    issue_request(btmx_pkg::ReqQuery, '0);
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(1) << (btmx_pkg::KeyBits - 1));
    issue_request(btmx_pkg::ReqInsert, btmx_pkg::key_t'(1) << (btmx_pkg::KeyBits - 1));
    issue_request(btmx_pkg::ReqInsert, btmx_pkg::key_t'(1));
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(49'h0_AAAA_AAAA_AAAA));
    issue_request(btmx_pkg::ReqInsert, btmx_pkg::key_t'(49'h0_AAAA_AAAA_AAAA));
    issue_request(btmx_pkg::ReqInsert, btmx_pkg::key_t'(49'h1_5555_5555_5555));
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(49'h1_5555_5555_5555));
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(49'h0_AAAA_AAAA_AAAB));
    issue_request(btmx_pkg::ReqQuery, btmx_pkg::key_t'(1));
    issue_request(btmx_pkg::ReqQuery, '1);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) random_item();
  endtask

  // fill the node pool, then check that inserts are refused and the trie is untouched
  task automatic test_pool_exhaustion();
    sender_idle_pct = 12;
    while (btmx_pkg::NodeCount - next_node >= btmx_pkg::KeyBits) begin
      if ($urandom_range(19) == 0)
        random_item();
      else
        issue_request(btmx_pkg::ReqInsert, rand_key());
    end
    issue_request(btmx_pkg::ReqInsert, trie_keys[$urandom_range(trie_keys.size() - 1)]);
    issue_request(btmx_pkg::ReqInsert, rand_key());
    issue_request(btmx_pkg::ReqInsert, '0);
    issue_request(btmx_pkg::ReqInsert, '1);
    issue_request(btmx_pkg::ReqQuery, '0);
    issue_request(btmx_pkg::ReqQuery, '1);
    sender_idle_pct = 46;
    repeat (20) random_item();
  endtask

  initial begin
    trie_link[0][0] = '0;
    trie_link[0][1] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_query();
    test_extreme_keys();
    test_random_traffic(70, 0);
    test_random_traffic(70, 46);
    test_random_traffic(70, 12);
    test_pool_exhaustion();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
